>>> sv/lcg_scaled_sample_histogram_defines.svh
// Assertion macros shared by the checker of the LCG sample histogram.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LCG_SCALED_SAMPLE_HISTOGRAM_DEFINES_SVH
`define LCG_SCALED_SAMPLE_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCGH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCGH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lcgh_pkg.sv
// Shared types and constants of the LCG sample histogram.
// No dependencies; every module of the block imports this package.
package lcgh_pkg;

  localparam logic [31:0] LCG_MUL       = 32'd1103515245;
  localparam logic [31:0] LCG_ADD       = 32'd12345;
  localparam logic [31:0] SEED_RESET    = 32'd1;
  localparam logic [30:0] DIVISOR_RESET = 31'd100000;

  localparam int unsigned RAW_W  = 31;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CNT_W  = 32;

  localparam int unsigned BIN_COUNT = 4096;
  localparam int unsigned BIN_W     = $clog2(BIN_COUNT);

  localparam int unsigned FIFO_DEPTH = 2;

  // Configuration address space: two 32-bit registers.
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned REG_IDX_W = ADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SEED    = 1'b0,
    REG_DIVISOR = 1'b1
  } reg_idx_t;

  // One drawn sample on its way from the front to the back.
  typedef struct packed {
    logic             restart;
    logic [RAW_W-1:0] raw;
  } item_t;

  // Status reported by the back part.
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

>>> sv/lcg_scaled_sample_histogram.sv
// Top level of the LCG sample histogram: configuration, front, queue and back.
// Depends on lcgh_pkg, lcgh_cfg, lcgh_front, lcgh_fifo and lcgh_back.
//
// Each accepted transaction on the input channel is one draw: the 32-bit
// generator steps (restart reloads it from seed first and resets min and
// max), the low 31 bits are scaled by the divisor in IEEE single precision
// and truncated, and one result transaction reports the value, the sample,
// the updated saturating bin count and the running extremes. Draws are
// accepted into a two-entry queue one per cycle while it has room and no
// clearing pass runs; the back part works on one sample at a time, through
// the one-bit-per-cycle operand normalization and the 26-step restoring
// divider (a zero sample skips both), and takes the next sample once the last
// has reached the output registers. After reset the histogram memory is swept
// to zero, during which no draw is accepted; register writes work then.
module lcg_scaled_sample_histogram (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 value,
  output logic [30:0]                 raw_sample,
  output logic                        in_range,
  output logic [31:0]                 bin_count,
  output logic [31:0]                 min_value,
  output logic [31:0]                 max_value,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcgh_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lcgh_pkg::*;

  logic [31:0] seed;
  logic [30:0] divisor;
  logic        push;
  item_t       push_item;
  logic        pop;
  item_t       pop_item;
  logic        q_full;
  logic        q_empty;
  back_stat_t  stat;

  lcgh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed    (seed),
    .divisor (divisor)
  );

  lcgh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .seed      (seed),
    .q_full    (q_full),
    .stat      (stat),
    .push      (push),
    .push_item (push_item)
  );

  lcgh_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  lcgh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .divisor    (divisor),
    .q_empty    (q_empty),
    .pop_item   (pop_item),
    .pop        (pop),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .raw_sample (raw_sample),
    .in_range   (in_range),
    .bin_count  (bin_count),
    .min_value  (min_value),
    .max_value  (max_value)
  );

endmodule

>>> sv/lcgh_cfg.sv
// APB-style configuration registers (seed and divisor).
// Depends on lcgh_pkg.
module lcgh_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lcgh_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [31:0]               seed,
  output logic [30:0]               divisor
);
  import lcgh_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed    <= SEED_RESET;
      divisor <= DIVISOR_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SEED:    seed    <= pwdata;
        REG_DIVISOR: divisor <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    case (idx)
      REG_SEED:    prdata = seed;
      REG_DIVISOR: prdata = {1'b0, divisor};
      default:     prdata = '0;
    endcase
  end

endmodule

>>> sv/lcgh_front.sv
// Front part: accepts draw requests and steps the generator state.
// Depends on lcgh_pkg.
module lcgh_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                restart,
  input  logic [31:0]         seed,
  input  logic                q_full,
  input  lcgh_pkg::back_stat_t stat,
  output logic                push,
  output lcgh_pkg::item_t     push_item
);
  import lcgh_pkg::*;

  logic [31:0] gen_state;
  logic [31:0] base;
  logic [31:0] gen_state_next;

  // No draws during the histogram clearing pass or with the queue full.
  assign in_ready = !q_full && !stat.clearing;
  assign push     = in_valid && in_ready;

  // One multiply-add per draw, modulo 2^32.
  assign base           = restart ? seed : gen_state;
  assign gen_state_next = base * LCG_MUL + LCG_ADD;

  assign push_item.restart = restart;
  assign push_item.raw     = gen_state_next[RAW_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= 32'd1;
    end else if (push) begin
      gen_state <= gen_state_next;
    end
  end

endmodule

>>> sv/lcgh_fifo.sv
// Short queue of drawn samples between the front and the back.
// Depends on lcgh_pkg.
module lcgh_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcgh_pkg::item_t push_item,
  input  logic            pop,
  output lcgh_pkg::item_t pop_item,
  output logic            full,
  output logic            empty
);
  import lcgh_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned OCC_W = $clog2(FIFO_DEPTH + 1);

  item_t            slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [OCC_W-1:0] occ;

  assign full     = (occ == OCC_W'(FIFO_DEPTH));
  assign empty    = (occ == '0);
  assign pop_item = slots[rptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      occ  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        occ <= occ + 1'b1;
      end else if (pop && !push) begin
        occ <= occ - 1'b1;
      end
    end
  end

endmodule

>>> sv/lcgh_back.sv
// Back part: single-precision scaling, histogram update and running min/max.
// Depends on lcgh_pkg; holds the histogram memory.
module lcgh_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [30:0]          divisor,
  input  logic                 q_empty,
  input  lcgh_pkg::item_t      pop_item,
  output logic                 pop,
  output lcgh_pkg::back_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          value,
  output logic [30:0]          raw_sample,
  output logic                 in_range,
  output logic [31:0]          bin_count,
  output logic [31:0]          min_value,
  output logic [31:0]          max_value
);
  import lcgh_pkg::*;

  localparam int unsigned DIV_STEPS = 26;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NORM,
    ST_RND,
    ST_DIV,
    ST_FIN,
    ST_RD,
    ST_UPD
  } state_t;

  state_t            state;
  logic [BIN_W-1:0]  clr_addr;
  logic [30:0]       nr;
  logic [30:0]       nd;
  logic [4:0]        pr;
  logic [4:0]        pd;
  logic [23:0]       md;
  logic [25:0]       rem;
  logic [25:0]       quo;
  logic [STEP_W-1:0] step;
  logic [31:0]       val;
  logic [30:0]       raw_q;
  logic              restart_q;
  logic              hit;
  logic [31:0]       run_min;
  logic [31:0]       run_max;

  logic [CNT_W-1:0]  hist [BIN_COUNT];
  logic [CNT_W-1:0]  rd_data;
  logic              mem_we;
  logic [BIN_W-1:0]  mem_wa;
  logic [CNT_W-1:0]  mem_wd;
  logic              mem_re;

  // Input rounding of both operands to 24 significant bits.
  logic [24:0]       r_sum;
  logic [24:0]       d_sum;
  // Quotient normalization, rounding and truncation to an integer.
  logic [25:0]       q2;
  logic              q_shift;
  logic              q_sticky;
  logic [24:0]       q_sum;
  logic [23:0]       q_man;
  logic signed [7:0] k;
  logic [7:0]        nk;
  logic [31:0]       fin_val;
  // Divider step.
  logic              ge;
  logic [25:0]       rem_sub;
  // Histogram and extremes update.
  logic              out_free;
  logic [CNT_W-1:0]  new_cnt;
  logic [31:0]       min_base;
  logic [31:0]       max_base;
  logic [31:0]       min_next;
  logic [31:0]       max_next;

  assign stat.clearing = (state == ST_CLEAR);
  assign pop           = (state == ST_IDLE) && !q_empty;
  assign out_free      = !out_valid || out_ready;

  // Round to nearest even of the normalized operands.
  assign r_sum = {1'b0, nr[30:7]} + 25'(nr[6] & ((|nr[5:0]) | nr[7]));
  assign d_sum = {1'b0, nd[30:7]} + 25'(nd[6] & ((|nd[5:0]) | nd[7]));

  // One restoring division step.
  assign ge      = (rem >= {2'b00, md});
  assign rem_sub = ge ? rem - {2'b00, md} : rem;

  // Final quotient: normalize, round, scale by the exponent, truncate.
  always_comb begin
    q_shift  = !quo[25];
    q2       = q_shift ? {quo[24:0], 1'b0} : quo;
    q_sticky = q2[0] | (rem != '0);
    q_sum    = {1'b0, q2[25:2]} + 25'(q2[1] & (q_sticky | q2[2]));
    q_man    = q_sum[24] ? 24'h80_0000 : q_sum[23:0];
    k        = $signed({3'b000, pr}) - $signed({3'b000, pd})
             - $signed({7'b0, q_shift}) + $signed({7'b0, q_sum[24]}) - 8'sd23;
    nk       = 8'(-k);
    if (!k[7]) begin
      fin_val = {8'b0, q_man} << k[3:0];
    end else if (nk >= 8'd24) begin
      fin_val = '0;
    end else begin
      fin_val = {8'b0, q_man >> nk[4:0]};
    end
  end

  // Saturating bin increment and running extremes.
  always_comb begin
    new_cnt  = (rd_data == '1) ? rd_data : rd_data + 1'b1;
    min_base = restart_q ? '1 : run_min;
    max_base = restart_q ? '0 : run_max;
    min_next = (val < min_base) ? val : min_base;
    max_next = (val > max_base) ? val : max_base;
  end

  // Memory port control: zero sweep after reset, then read-modify-write.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = val[BIN_W-1:0];
    mem_wd = new_cnt;
    mem_re = (state == ST_RD);
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else if (state == ST_UPD && out_free && hit) begin
      mem_we = 1'b1;
    end
  end

  // Histogram memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= hist[val[BIN_W-1:0]];
    end
  end

  // Sequencer with its datapath and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      run_min   <= '1;
      run_max   <= '0;
    end else begin
      // The update state loads the next result itself when the slot frees.
      if (out_valid && out_ready && state != ST_UPD) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BIN_W'(BIN_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            raw_q     <= pop_item.raw;
            restart_q <= pop_item.restart;
            nr        <= pop_item.raw;
            nd        <= (divisor == '0) ? 31'd1 : divisor;
            pr        <= 5'd30;
            pd        <= 5'd30;
            state     <= ST_NORM;
          end
        end
        ST_NORM: begin
          // One bit of left shift per cycle until both leading bits are set.
          if (nr == '0) begin
            val   <= '0;
            state <= ST_RD;
          end else if (nr[30] && nd[30]) begin
            state <= ST_RND;
          end else begin
            if (!nr[30]) begin
              nr <= {nr[29:0], 1'b0};
              pr <= pr - 1'b1;
            end
            if (!nd[30]) begin
              nd <= {nd[29:0], 1'b0};
              pd <= pd - 1'b1;
            end
          end
        end
        ST_RND: begin
          rem   <= r_sum[24] ? 26'h80_0000 : {2'b00, r_sum[23:0]};
          md    <= d_sum[24] ? 24'h80_0000 : d_sum[23:0];
          pr    <= pr + 5'(r_sum[24]);
          pd    <= pd + 5'(d_sum[24]);
          quo   <= '0;
          step  <= STEP_W'(DIV_STEPS - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          quo  <= {quo[24:0], ge};
          rem  <= {rem_sub[24:0], 1'b0};
          step <= step - 1'b1;
          if (step == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          val   <= fin_val;
          state <= ST_RD;
        end
        ST_RD: begin
          hit   <= (val < 32'(BIN_COUNT));
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (out_free) begin
            run_min    <= min_next;
            run_max    <= max_next;
            out_valid  <= 1'b1;
            value      <= val;
            raw_sample <= raw_q;
            in_range   <= hit;
            bin_count  <= hit ? new_cnt : '0;
            min_value  <= min_next;
            max_value  <= max_next;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/lcgh_checker.sv
// Port-level checker of the LCG sample histogram, bound to the top level.
// Depends on lcgh_pkg and lcg_scaled_sample_histogram_defines.svh.
`include "lcg_scaled_sample_histogram_defines.svh"

module lcgh_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value,
  input logic        in_range,
  input logic [31:0] bin_count,
  input logic [31:0] min_value,
  input logic [31:0] max_value
);
  import lcgh_pkg::*;

  // A result waiting for the consumer holds its value.
  `LCGH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value), "result changed while stalled")

  // A value beyond the bins reports a zero count.
  `LCGH_ASSERT_NOW(a_out_of_range_zero, out_valid && !in_range, bin_count == '0, "count without a bin")

  // A value inside the bins has been counted at least once.
  `LCGH_ASSERT_NOW(a_in_range_count, out_valid && in_range, value < 32'(BIN_COUNT) && bin_count != '0, "bad bin count")

  // The running extremes enclose the value just drawn.
  `LCGH_ASSERT_NOW(a_extremes, out_valid, min_value <= value && max_value >= value, "extremes exclude value")

endmodule

bind lcg_scaled_sample_histogram lcgh_checker u_lcgh_checker (.*);

>>> bench/lcgh_checker.sv
// Scoreboard for the LCG sample histogram: it watches the draw, result and register ports.
// It predicts each result and counts mismatches. Depends on lcgh_pkg only.
`timescale 1ns / 100ps

module lcgh_scoreboard (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        restart,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [31:0]                 value,
  input  logic [30:0]                 raw_sample,
  input  logic                        in_range,
  input  logic [31:0]                 bin_count,
  input  logic [31:0]                 min_value,
  input  logic [31:0]                 max_value,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [lcgh_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          errors,
  output int                          pending
);
  import lcgh_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [30:0] raw_sample;
    logic        in_range;
    logic [31:0] bin_count;
    logic [31:0] min_value;
    logic [31:0] max_value;
  } draw_result_t;

  logic [31:0]  seed_q;
  logic [30:0]  divisor_q;
  logic [31:0]  gen_q;
  logic [31:0]  min_q;
  logic [31:0]  max_q;
  logic [31:0]  hist_q [BIN_COUNT];
  draw_result_t results_due [$];

  assign pending = results_due.size();

  // Rounds a positive integer to 24 significant bits, nearest-even, with an extra sticky
  // bit from below. The result is sig * 2^e with sig normalized to bit 23.
  function automatic void round_to_single(input longint unsigned x, input bit sticky,
                                          output longint unsigned sig, output int e);
    int p;
    int sh;
    longint unsigned rem;
    longint unsigned half;
    p = 63;
    while (p > 0 && x[p] == 1'b0) p--;
    if (p <= 23) begin
      sig = x << (23 - p);
      e = p - 23;
    end else begin
      sh = p - 23;
      sig = x >> sh;
      rem = x & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && (sticky || sig[0]))) sig++;
      if (sig == (64'd1 << 24)) begin
        sig = sig >> 1;
        sh++;
      end
      e = sh;
    end
  endfunction

  // Single-precision raw / divisor, truncated toward zero.
  function automatic logic [31:0] scaled_sample(input logic [30:0] raw, input logic [30:0] dv);
    longint unsigned num_sig;
    longint unsigned den_sig;
    longint unsigned quo;
    longint unsigned q_sig;
    longint unsigned v;
    int num_e;
    int den_e;
    int q_e;
    int total_e;
    if (raw == 0) return 32'd0;
    round_to_single(64'(raw), 1'b0, num_sig, num_e);
    round_to_single((dv == 0) ? 64'd1 : 64'(dv), 1'b0, den_sig, den_e);
    quo = (num_sig << 26) / den_sig;
    round_to_single(quo, ((num_sig << 26) % den_sig) != 0, q_sig, q_e);
    total_e = num_e - den_e - 26 + q_e;
    if (total_e >= 0) v = q_sig << total_e;
    else if (total_e <= -63) v = 0;
    else v = q_sig >> (-total_e);
    return v[31:0];
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    draw_result_t exp_r;
    logic [31:0] g;
    logic [31:0] v;
    if (rst) begin
      seed_q <= SEED_RESET;
      divisor_q <= DIVISOR_RESET;
      gen_q <= 32'd1;
      min_q <= '1;
      max_q <= '0;
      for (int i = 0; i < BIN_COUNT; i++) hist_q[i] = '0;
      results_due.delete();
    end else begin
      // Register writes on the configuration port.
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr >> 2) == REG_SEED) seed_q <= pwdata;
        else divisor_q <= pwdata[30:0];
      end

      // Predict the result of each accepted draw transaction.
      if (in_valid && in_ready) begin
        g = restart ? seed_q : gen_q;
        exp_r.min_value = restart ? '1 : min_q;
        exp_r.max_value = restart ? '0 : max_q;
        g = g * LCG_MUL + LCG_ADD;
        v = scaled_sample(g[30:0], divisor_q);
        exp_r.value = v;
        exp_r.raw_sample = g[30:0];
        exp_r.in_range = v < BIN_COUNT;
        exp_r.bin_count = '0;
        if (exp_r.in_range) begin
          if (hist_q[v] != '1) hist_q[v] = hist_q[v] + 1;
          exp_r.bin_count = hist_q[v];
        end
        if (v < exp_r.min_value) exp_r.min_value = v;
        if (v > exp_r.max_value) exp_r.max_value = v;
        gen_q <= g;
        min_q <= exp_r.min_value;
        max_q <= exp_r.max_value;
        results_due.push_back(exp_r);
      end

      // Compare each accepted result transaction with the oldest prediction.
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result transaction with no draw outstanding", $realtime);
          errors++;
        end else begin
          exp_r = results_due.pop_front();
          if (value !== exp_r.value) report_mismatch("value", value, exp_r.value);
          if (raw_sample !== exp_r.raw_sample)
            report_mismatch("raw_sample", 32'(raw_sample), 32'(exp_r.raw_sample));
          if (in_range !== exp_r.in_range)
            report_mismatch("in_range", 32'(in_range), 32'(exp_r.in_range));
          if (bin_count !== exp_r.bin_count)
            report_mismatch("bin_count", bin_count, exp_r.bin_count);
          if (min_value !== exp_r.min_value)
            report_mismatch("min_value", min_value, exp_r.min_value);
          if (max_value !== exp_r.max_value)
            report_mismatch("max_value", max_value, exp_r.max_value);
        end
      end
    end
  end

endmodule

>>> bench/tb_lcg_scaled_sample_histogram.sv
// Testbench top for the LCG sample histogram: clock, reset, draw and register stimulus.
// Depends on lcgh_pkg, lcg_scaled_sample_histogram and lcgh_scoreboard.
`timescale 1ns / 100ps

module tb_lcg_scaled_sample_histogram;
  import lcgh_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value;
  logic [30:0] raw_sample;
  logic        in_range;
  logic [31:0] bin_count;
  logic [31:0] min_value;
  logic [31:0] max_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  bit          hold_off = 1'b0;
  bit          busy_sink = 1'b0;
  int          idle_cycles = 0;

  always #1 clk = ~clk;

  lcg_scaled_sample_histogram DUT (.*);

  lcgh_scoreboard u_scoreboard (.*);

  // Watchdog: give up after a long stretch with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_lcg_scaled_sample_histogram failed");
      $finish;
    end
  end

  // Result side: random stalls, a long hold-off on request, and busy stretches.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end else if (busy_sink) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 150)) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 49) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  task automatic send_draw(input bit do_restart, input int gap);
    in_valid <= 1'b1;
    restart <= do_restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      restart <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Let every outstanding draw drain before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] seed_val, input logic [31:0] div_val,
                           input int draws, input int restart_pct);
    drain();
    write_reg(REG_SEED, seed_val);
    write_reg(REG_DIVISOR, div_val);
    busy_sink = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < draws; i++)
      send_draw(i == 0 || $urandom_range(0, 99) < restart_pct,
                busy_sink ? 0 : pick_gap());
    busy_sink = 1'b0;
  endtask

  initial begin
    logic [31:0] dv;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the first two draws run from seed 1 without a restart, the third restarts.
    send_draw(1'b0, 0);
    send_draw(1'b0, 3);
    send_draw(1'b1, 0);
    // Divisor of one: values up to the top, nearly all beyond the bins.
    run_phase(32'hFFFF_FFFF, 32'd1, 4, 25);
    // Divisor register of zero behaves as one; seed of zero.
    run_phase(32'd0, 32'h8000_0000, 4, 25);
    // Largest divisor: values of zero and one only, bins filling fast.
    run_phase(32'h1234_5678, 32'hFFFF_FFFF, 5, 0);
    // Divisor putting nearly every value within the bins, top bin reachable.
    run_phase(32'hDEAD_BEEF, 32'd524288, 5, 20);

    // Fill the block while the result side holds off.
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) send_draw($urandom_range(0, 9) == 0, 0);

    // Random phases over a mix of divisor ranges.
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 5))
        0: dv = 32'd1;
        1: dv = 32'h7FFF_FFFF;
        2: dv = $urandom_range(1, 4096);
        3: dv = $urandom_range(300000, 2000000);
        4: dv = $urandom();
        default: dv = 32'd100000;
      endcase
      run_phase($urandom(), dv, 85, $urandom_range(0, 15));
    end

    drain();
    if (errors == 0) $display("tb_lcg_scaled_sample_histogram passed");
    else $display("tb_lcg_scaled_sample_histogram failed");
    $finish;
  end

endmodule
